[src/bhpd_pkg.sv]
// Shared types and protocol constants for the host packet deframer.
package bhpd_pkg;

  localparam int unsigned HDR_KEEP = 20;
  localparam int unsigned POS_W = 11;
  localparam int unsigned LEN_W = 10;
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned VALUE_FIRST_POS = 9;

  localparam logic [7:0] START_MASK = 8'h78;
  localparam logic [7:0] LEN_HI_MASK = 8'h03;
  localparam int unsigned TYPE_BIT = 7;

  localparam logic [2:0] KIND_BAD_START = 3'd0;
  localparam logic [2:0] KIND_HELLO = 3'd1;
  localparam logic [2:0] KIND_CONNECT_RSP = 3'd2;
  localparam logic [2:0] KIND_BOOT = 3'd3;
  localparam logic [2:0] KIND_CONN_STATUS = 3'd4;
  localparam logic [2:0] KIND_PROC_DONE = 3'd5;
  localparam logic [2:0] KIND_ATTR_VALUE = 3'd6;
  localparam logic [2:0] KIND_VALUE_BYTE = 3'd7;

  localparam logic [7:0] CLS_SYSTEM = 8'd0;
  localparam logic [7:0] CLS_CONNECTION = 8'd3;
  localparam logic [7:0] CLS_ATTR_CLIENT = 8'd4;
  localparam logic [7:0] CLS_GAP = 8'd6;

  localparam logic [7:0] ID_HELLO = 8'd1;
  localparam logic [7:0] ID_CONNECT_DIRECT = 8'd3;
  localparam logic [7:0] ID_BOOT = 8'd0;
  localparam logic [7:0] ID_CONN_STATUS = 8'd0;
  localparam logic [7:0] ID_PROC_DONE = 8'd1;
  localparam logic [7:0] ID_ATTR_VALUE = 8'd5;

  typedef logic [HDR_KEEP-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  connection;
    logic [7:0]  small_a;
    logic [7:0]  small_b;
    logic [7:0]  small_c;
    logic [15:0] word_0;
    logic [15:0] word_1;
    logic [15:0] word_2;
    logic [15:0] word_3;
    logic [15:0] word_4;
    logic [47:0] peer_address;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]       cnt;
    res_t             res0;
    res_t             res1;
    logic             advance;
    logic [POS_W-1:0] position_next;
    logic             len_load;
    logic [LEN_W-1:0] len_value;
  } dec_t;

endpackage

[src/bhpd_decode.sv]
// Per-byte decode: packet position tracking and result assembly.
module bhpd_decode (
  input  logic [7:0]                 rx_byte,
  input  logic [bhpd_pkg::POS_W-1:0] position,
  input  logic [bhpd_pkg::LEN_W-1:0] payload_length,
  input  bhpd_pkg::hdr_t             hdr,
  output bhpd_pkg::dec_t             dec
);

  function automatic logic [15:0] le16(bhpd_pkg::hdr_t h, int unsigned i);
    return {h[i+1], h[i]};
  endfunction

  always_comb begin
    bhpd_pkg::res_t             val_res;
    bhpd_pkg::res_t             pkt_res;
    logic                       is_val;
    logic                       found;
    logic                       at_end;
    logic [bhpd_pkg::POS_W-1:0] pos_inc;
    logic [7:0]                 cls;
    logic [7:0]                 id;

    dec = '0;
    val_res = '0;
    pkt_res = '0;
    found = 1'b1;
    cls = hdr[2];
    id = hdr[3];
    pos_inc = position + bhpd_pkg::POS_W'(1);
    is_val = 1'b0;
    at_end = 1'b0;

    if (position == '0) begin
      if ((rx_byte & bhpd_pkg::START_MASK) != 8'h00) begin
        dec.cnt = 2'd1;
        dec.res0.kind = bhpd_pkg::KIND_BAD_START;
        dec.res0.last = 1'b1;
        dec.advance = 1'b0;
        dec.position_next = '0;
      end else begin
        dec.advance = 1'b1;
        dec.position_next = bhpd_pkg::POS_W'(1);
      end
    end else begin
      dec.advance = 1'b1;
      dec.position_next = pos_inc;
      is_val = (position >= bhpd_pkg::POS_W'(bhpd_pkg::VALUE_FIRST_POS)) &&
               hdr[0][bhpd_pkg::TYPE_BIT] && (cls == bhpd_pkg::CLS_ATTR_CLIENT) &&
               (id == bhpd_pkg::ID_ATTR_VALUE);
      val_res.kind = bhpd_pkg::KIND_VALUE_BYTE;
      val_res.connection = hdr[4];
      val_res.small_c = rx_byte;

      if (pos_inc == bhpd_pkg::POS_W'(2)) begin
        dec.len_load = 1'b1;
        dec.len_value = {hdr[0][1:0] & bhpd_pkg::LEN_HI_MASK[1:0], rx_byte};
      end else if (pos_inc == bhpd_pkg::POS_W'(payload_length) +
                             bhpd_pkg::POS_W'(bhpd_pkg::HDR_BYTES)) begin
        at_end = 1'b1;
        dec.position_next = '0;
        if (!hdr[0][bhpd_pkg::TYPE_BIT]) begin
          if (cls == bhpd_pkg::CLS_SYSTEM && id == bhpd_pkg::ID_HELLO) begin
            pkt_res.kind = bhpd_pkg::KIND_HELLO;
          end else if (cls == bhpd_pkg::CLS_GAP && id == bhpd_pkg::ID_CONNECT_DIRECT) begin
            pkt_res.kind = bhpd_pkg::KIND_CONNECT_RSP;
            pkt_res.word_0 = le16(hdr, 4);
            pkt_res.connection = hdr[6];
          end else begin
            found = 1'b0;
          end
        end else if (cls == bhpd_pkg::CLS_SYSTEM && id == bhpd_pkg::ID_BOOT) begin
          pkt_res.kind = bhpd_pkg::KIND_BOOT;
          pkt_res.word_0 = le16(hdr, 4);
          pkt_res.word_1 = le16(hdr, 6);
          pkt_res.word_2 = le16(hdr, 8);
          pkt_res.word_3 = le16(hdr, 10);
          pkt_res.word_4 = le16(hdr, 12);
          pkt_res.small_a = hdr[14];
          pkt_res.small_b = hdr[15];
        end else if (cls == bhpd_pkg::CLS_CONNECTION && id == bhpd_pkg::ID_CONN_STATUS) begin
          pkt_res.kind = bhpd_pkg::KIND_CONN_STATUS;
          pkt_res.connection = hdr[4];
          pkt_res.small_a = hdr[5];
          pkt_res.peer_address = {hdr[11], hdr[10], hdr[9], hdr[8], hdr[7], hdr[6]};
          pkt_res.small_b = hdr[12];
          pkt_res.word_0 = le16(hdr, 13);
          pkt_res.word_1 = le16(hdr, 15);
          pkt_res.word_2 = le16(hdr, 17);
          pkt_res.small_c = hdr[19];
        end else if (cls == bhpd_pkg::CLS_ATTR_CLIENT && id == bhpd_pkg::ID_PROC_DONE) begin
          pkt_res.kind = bhpd_pkg::KIND_PROC_DONE;
          pkt_res.connection = hdr[4];
          pkt_res.word_0 = le16(hdr, 5);
          pkt_res.word_1 = le16(hdr, 7);
        end else if (cls == bhpd_pkg::CLS_ATTR_CLIENT && id == bhpd_pkg::ID_ATTR_VALUE) begin
          pkt_res.kind = bhpd_pkg::KIND_ATTR_VALUE;
          pkt_res.connection = hdr[4];
          pkt_res.word_0 = le16(hdr, 5);
          pkt_res.small_a = hdr[7];
          if (pos_inc > bhpd_pkg::POS_W'(bhpd_pkg::VALUE_FIRST_POS)) begin
            pkt_res.word_2 =
              16'(pos_inc - bhpd_pkg::POS_W'(bhpd_pkg::VALUE_FIRST_POS));
          end
        end else begin
          found = 1'b0;
        end
      end

      if (is_val) begin
        dec.res0 = val_res;
        if (at_end && found) begin
          dec.cnt = 2'd2;
          dec.res1 = pkt_res;
          dec.res1.last = 1'b1;
        end else begin
          dec.cnt = 2'd1;
          dec.res0.last = 1'b1;
        end
      end else if (at_end && found) begin
        dec.cnt = 2'd1;
        dec.res0 = pkt_res;
        dec.res0.last = 1'b1;
      end
    end
  end

endmodule

[src/ble_host_packet_deframer.sv]
// Top level of the length-prefixed host packet deframer.
// Takes one serial byte per transaction on the input channel and emits packet summaries
// and attribute-value payload bytes on the output channel. A byte is registered on
// entry, then decoded and written into a two-entry result queue; the byte is held in
// its register while the queue lacks room for its results. One byte is taken
// every cycle as long as the output is drained; a byte that ends an attribute-value
// event yields two results, which fill the two-entry result queue and can hold
// back the next byte. The first 20 packet bytes are kept in flip-flops and
// cleared when a packet starts, so header bytes not received read as zero.
module ble_host_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  connection,
  output logic [7:0]  small_a,
  output logic [7:0]  small_b,
  output logic [7:0]  small_c,
  output logic [15:0] word_0,
  output logic [15:0] word_1,
  output logic [15:0] word_2,
  output logic [15:0] word_3,
  output logic [15:0] word_4,
  output logic [47:0] peer_address,
  output logic        last
);

  logic                       stage_valid;
  logic [7:0]                 stage_byte;
  logic [bhpd_pkg::POS_W-1:0] position;
  logic [bhpd_pkg::LEN_W-1:0] payload_length;
  bhpd_pkg::hdr_t             hdr;
  bhpd_pkg::hdr_t             hdr_next;
  bhpd_pkg::dec_t             dec;
  bhpd_pkg::res_t             queue [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 cnt;
  logic [1:0]                 free;
  logic                       go;
  logic                       pop;
  bhpd_pkg::res_t             head;

  always_comb begin
    for (int i = 0; i < bhpd_pkg::HDR_KEEP; i++) begin
      if (position == '0) begin
        hdr_next[i] = (i == 0) ? stage_byte : 8'h00;
      end else if (position == bhpd_pkg::POS_W'(i)) begin
        hdr_next[i] = stage_byte;
      end else begin
        hdr_next[i] = hdr[i];
      end
    end
  end

  bhpd_decode u_decode (
    .rx_byte        (stage_byte),
    .position       (position),
    .payload_length (payload_length),
    .hdr            (hdr_next),
    .dec            (dec)
  );

  assign free = 2'd2 - cnt;
  assign go = stage_valid && (dec.cnt <= free);
  assign in_ready = !stage_valid || go;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      payload_length <= '0;
    end else if (go) begin
      position <= dec.position_next;
      if (dec.len_load) begin
        payload_length <= dec.len_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && dec.advance) begin
      hdr <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && dec.cnt != 2'd0) begin
      queue[wr_ptr] <= dec.res0;
    end
    if (go && dec.cnt == 2'd2) begin
      queue[~wr_ptr] <= dec.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (go) begin
        wr_ptr <= wr_ptr ^ dec.cnt[0];
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + (go ? dec.cnt : 2'd0) - {1'b0, pop};
    end
  end

  assign head = queue[rd_ptr];
  assign out_valid = (cnt != 2'd0);
  assign kind = head.kind;
  assign connection = head.connection;
  assign small_a = head.small_a;
  assign small_b = head.small_b;
  assign small_c = head.small_c;
  assign word_0 = head.word_0;
  assign word_1 = head.word_1;
  assign word_2 = head.word_2;
  assign word_3 = head.word_3;
  assign word_4 = head.word_4;
  assign peer_address = head.peer_address;
  assign last = head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue count out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    go && dec.cnt == 2'd2 |->
      dec.res0.kind == bhpd_pkg::KIND_VALUE_BYTE && !dec.res0.last && dec.res1.last)
    else $error("two-result transaction out of order");

  a_bad_start_hold: assert property (@(posedge clk) disable iff (rst)
    go && position == '0 && dec.cnt != 2'd0 |=> position == '0)
    else $error("rejected start byte moved the packet position");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    stage_valid && cnt == 2'd2 && dec.cnt != 2'd0 |-> !in_ready)
    else $error("byte accepted with no room for its results");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the host packet deframer: directed and random framed traffic, checked per field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TOTAL_BYTES = 1200;

  typedef struct packed {
    logic       drain;
    logic [7:0] value;
  } tx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  connection;
  logic [7:0]  small_a;
  logic [7:0]  small_b;
  logic [7:0]  small_c;
  logic [15:0] word_0;
  logic [15:0] word_1;
  logic [15:0] word_2;
  logic [15:0] word_3;
  logic [15:0] word_4;
  logic [47:0] peer_address;
  logic        last;

  tx_item_t          tx_bytes[$];
  tx_item_t          next_item;
  bhpd_pkg::res_t    awaited[$];
  bhpd_pkg::res_t    got_rec;

  logic [bhpd_pkg::POS_W-1:0] frame_pos = '0;
  logic [bhpd_pkg::LEN_W-1:0] frame_len = '0;
  logic [7:0]                 frame_hdr [bhpd_pkg::HDR_KEEP];

  int unsigned send_idle = 0;
  int unsigned send_calm = 0;
  int unsigned recv_idle = 0;
  int unsigned recv_calm = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned packets_queued = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned kind_count [8];

  ble_host_packet_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .connection   (connection),
    .small_a      (small_a),
    .small_b      (small_b),
    .small_c      (small_c),
    .word_0       (word_0),
    .word_1       (word_1),
    .word_2       (word_2),
    .word_3       (word_3),
    .word_4       (word_4),
    .peer_address (peer_address),
    .last         (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] hdr_word(input int unsigned i);
    return {frame_hdr[i+1], frame_hdr[i]};
  endfunction

  // Advance the framing state by one byte and queue the records it should produce.
  function automatic void deframe_byte(input logic [7:0] b);
    bhpd_pkg::res_t summary;
    bhpd_pkg::res_t value_rec;
    bit             have_value;
    bit             have_summary;
    int unsigned    idx;
    summary = '0;
    value_rec = '0;
    have_value = 1'b0;
    have_summary = 1'b0;
    if (frame_pos == '0) begin
      if ((b & bhpd_pkg::START_MASK) != 8'h00) begin
        summary.kind = bhpd_pkg::KIND_BAD_START;
        summary.last = 1'b1;
        awaited.push_back(summary);
      end else begin
        foreach (frame_hdr[k]) frame_hdr[k] = 8'h00;
        frame_hdr[0] = b;
        frame_pos = bhpd_pkg::POS_W'(1);
      end
      return;
    end
    idx = 32'(frame_pos);
    if (idx < bhpd_pkg::HDR_KEEP) frame_hdr[idx] = b;
    frame_pos = frame_pos + 1'b1;
    if (idx >= bhpd_pkg::VALUE_FIRST_POS && frame_hdr[0][bhpd_pkg::TYPE_BIT] &&
        frame_hdr[2] == bhpd_pkg::CLS_ATTR_CLIENT && frame_hdr[3] == bhpd_pkg::ID_ATTR_VALUE) begin
      value_rec.kind = bhpd_pkg::KIND_VALUE_BYTE;
      value_rec.connection = frame_hdr[4];
      value_rec.small_c = b;
      have_value = 1'b1;
    end
    if (frame_pos == 2) begin
      frame_len = {frame_hdr[0][1:0], b};
    end else if (int'(frame_pos) == int'(frame_len) + bhpd_pkg::HDR_BYTES) begin
      have_summary = 1'b1;
      if (!frame_hdr[0][bhpd_pkg::TYPE_BIT]) begin
        if (frame_hdr[2] == bhpd_pkg::CLS_SYSTEM && frame_hdr[3] == bhpd_pkg::ID_HELLO) begin
          summary.kind = bhpd_pkg::KIND_HELLO;
        end else if (frame_hdr[2] == bhpd_pkg::CLS_GAP &&
                     frame_hdr[3] == bhpd_pkg::ID_CONNECT_DIRECT) begin
          summary.kind = bhpd_pkg::KIND_CONNECT_RSP;
          summary.word_0 = hdr_word(4);
          summary.connection = frame_hdr[6];
        end else begin
          have_summary = 1'b0;
        end
      end else if (frame_hdr[2] == bhpd_pkg::CLS_SYSTEM && frame_hdr[3] == bhpd_pkg::ID_BOOT) begin
        summary.kind = bhpd_pkg::KIND_BOOT;
        summary.word_0 = hdr_word(4);
        summary.word_1 = hdr_word(6);
        summary.word_2 = hdr_word(8);
        summary.word_3 = hdr_word(10);
        summary.word_4 = hdr_word(12);
        summary.small_a = frame_hdr[14];
        summary.small_b = frame_hdr[15];
      end else if (frame_hdr[2] == bhpd_pkg::CLS_CONNECTION &&
                   frame_hdr[3] == bhpd_pkg::ID_CONN_STATUS) begin
        summary.kind = bhpd_pkg::KIND_CONN_STATUS;
        summary.connection = frame_hdr[4];
        summary.small_a = frame_hdr[5];
        summary.peer_address = {frame_hdr[11], frame_hdr[10], frame_hdr[9],
                                frame_hdr[8], frame_hdr[7], frame_hdr[6]};
        summary.small_b = frame_hdr[12];
        summary.word_0 = hdr_word(13);
        summary.word_1 = hdr_word(15);
        summary.word_2 = hdr_word(17);
        summary.small_c = frame_hdr[19];
      end else if (frame_hdr[2] == bhpd_pkg::CLS_ATTR_CLIENT &&
                   frame_hdr[3] == bhpd_pkg::ID_PROC_DONE) begin
        summary.kind = bhpd_pkg::KIND_PROC_DONE;
        summary.connection = frame_hdr[4];
        summary.word_0 = hdr_word(5);
        summary.word_1 = hdr_word(7);
      end else if (frame_hdr[2] == bhpd_pkg::CLS_ATTR_CLIENT &&
                   frame_hdr[3] == bhpd_pkg::ID_ATTR_VALUE) begin
        summary.kind = bhpd_pkg::KIND_ATTR_VALUE;
        summary.connection = frame_hdr[4];
        summary.word_0 = hdr_word(5);
        summary.small_a = frame_hdr[7];
        summary.word_2 = (frame_pos > bhpd_pkg::VALUE_FIRST_POS) ?
                         16'(frame_pos - bhpd_pkg::VALUE_FIRST_POS) : 16'd0;
      end else begin
        have_summary = 1'b0;
      end
      frame_pos = '0;
    end
    if (have_value) begin
      value_rec.last = !have_summary;
      awaited.push_back(value_rec);
    end
    if (have_summary) begin
      summary.last = 1'b1;
      awaited.push_back(summary);
    end
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  function automatic void queue_noise();
    tx_item_t item;
    item.drain = 1'b0;
    item.value = 8'($urandom_range(0, 255));
    item.value[3 + $urandom_range(0, 3)] = 1'b1;
    tx_bytes.push_back(item);
  endfunction

  function automatic void queue_packet(input bit type_bit, input logic [7:0] cls,
                                       input logic [7:0] id,
                                       input logic [bhpd_pkg::LEN_W-1:0] len,
                                       input bit drain);
    tx_item_t item;
    item.drain = drain;
    item.value = {type_bit, 4'b0000, 1'($urandom_range(0, 1)), len[9:8]};
    tx_bytes.push_back(item);
    item.drain = 1'b0;
    item.value = len[7:0];
    tx_bytes.push_back(item);
    item.value = cls;
    tx_bytes.push_back(item);
    item.value = id;
    tx_bytes.push_back(item);
    for (int unsigned i = 0; i < len; i++) begin
      item.value = 8'($urandom_range(0, 255));
      tx_bytes.push_back(item);
    end
    packets_queued++;
  endfunction

  function automatic logic [bhpd_pkg::LEN_W-1:0] pick_len(input int unsigned natural);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return bhpd_pkg::LEN_W'(natural);
    if (r < 80) return bhpd_pkg::LEN_W'($urandom_range(0, natural + 2));
    return bhpd_pkg::LEN_W'($urandom_range(0, 40));
  endfunction

  function automatic void queue_random_traffic();
    int unsigned sel;
    bit          drain;
    sel = $urandom_range(0, 99);
    drain = ($urandom_range(0, 49) == 0);
    if (sel < 12) begin
      queue_packet(1'b0, bhpd_pkg::CLS_SYSTEM, bhpd_pkg::ID_HELLO, pick_len(0), drain);
    end else if (sel < 22) begin
      queue_packet(1'b0, bhpd_pkg::CLS_GAP, bhpd_pkg::ID_CONNECT_DIRECT, pick_len(3), drain);
    end else if (sel < 32) begin
      queue_packet(1'b1, bhpd_pkg::CLS_SYSTEM, bhpd_pkg::ID_BOOT, pick_len(12), drain);
    end else if (sel < 44) begin
      queue_packet(1'b1, bhpd_pkg::CLS_CONNECTION, bhpd_pkg::ID_CONN_STATUS, pick_len(16),
                   drain);
    end else if (sel < 56) begin
      queue_packet(1'b1, bhpd_pkg::CLS_ATTR_CLIENT, bhpd_pkg::ID_PROC_DONE, pick_len(5), drain);
    end else if (sel < 78) begin
      queue_packet(1'b1, bhpd_pkg::CLS_ATTR_CLIENT, bhpd_pkg::ID_ATTR_VALUE,
                   pick_len(5 + $urandom_range(0, 16)), drain);
    end else if (sel < 90) begin
      if ($urandom_range(0, 1) == 0)
        queue_packet(1'($urandom_range(0, 1)), 8'($urandom_range(0, 7)),
                     8'($urandom_range(0, 7)), pick_len(8), drain);
      else
        queue_packet(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), pick_len(8), drain);
    end else begin
      repeat ($urandom_range(1, 3)) queue_noise();
    end
  endfunction

  initial begin
    foreach (frame_hdr[k]) frame_hdr[k] = 8'h00;
    foreach (kind_count[k]) kind_count[k] = 0;

    // Bad start bytes, then each packet kind but attribute value, with no payload so fields read as zero.
    tx_bytes.push_back('{drain: 1'b0, value: 8'hFF});
    tx_bytes.push_back('{drain: 1'b0, value: 8'h78});
    tx_bytes.push_back('{drain: 1'b0, value: 8'h08});
    queue_packet(1'b0, bhpd_pkg::CLS_SYSTEM, bhpd_pkg::ID_HELLO, '0, 1'b0);
    queue_packet(1'b0, bhpd_pkg::CLS_GAP, bhpd_pkg::ID_CONNECT_DIRECT, '0, 1'b0);
    queue_packet(1'b1, bhpd_pkg::CLS_SYSTEM, bhpd_pkg::ID_BOOT, '0, 1'b0);
    queue_packet(1'b1, bhpd_pkg::CLS_CONNECTION, bhpd_pkg::ID_CONN_STATUS, '0, 1'b0);
    queue_packet(1'b1, bhpd_pkg::CLS_ATTR_CLIENT, bhpd_pkg::ID_PROC_DONE, '0, 1'b0);
    queue_packet(1'b1, bhpd_pkg::CLS_SYSTEM, bhpd_pkg::ID_HELLO, '0, 1'b0);
    // Value event that ends on a value byte.
    queue_packet(1'b1, bhpd_pkg::CLS_ATTR_CLIENT, bhpd_pkg::ID_ATTR_VALUE,
                 bhpd_pkg::LEN_W'(6), 1'b0);

    // Long streaming value event using the top length bit, and a long unknown packet.
    queue_packet(1'b1, bhpd_pkg::CLS_ATTR_CLIENT, bhpd_pkg::ID_ATTR_VALUE, 10'h201, 1'b1);
    queue_packet(1'b0, bhpd_pkg::CLS_SYSTEM, 8'hFF,
                 bhpd_pkg::LEN_W'($urandom_range(256, 280)), 1'b0);

    while (tx_bytes.size() < TOTAL_BYTES) queue_random_traffic();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d packets plus bad starts; checked %0d results.",
             bytes_taken, packets_queued, results_checked);
    $display("Results by kind, bad start through value byte: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5], kind_count[6], kind_count[7]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(rx_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_idle != 0) begin
          send_idle--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0 && !(tx_bytes[0].drain && awaited.size() != 0)) begin
          next_item = tx_bytes.pop_front();
          rx_byte <= next_item.value;
          in_valid <= 1'b1;
          send_idle = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        kind_count[kind]++;
        if (awaited.size() == 0) begin
          $error("unexpected result of kind %0d", kind);
          mismatches++;
        end else begin
          got_rec = awaited.pop_front();
          results_checked++;
          check_field("kind", 48'(got_rec.kind), 48'(kind));
          check_field("connection", 48'(got_rec.connection), 48'(connection));
          check_field("small_a", 48'(got_rec.small_a), 48'(small_a));
          check_field("small_b", 48'(got_rec.small_b), 48'(small_b));
          check_field("small_c", 48'(got_rec.small_c), 48'(small_c));
          check_field("word_0", 48'(got_rec.word_0), 48'(word_0));
          check_field("word_1", 48'(got_rec.word_1), 48'(word_1));
          check_field("word_2", 48'(got_rec.word_2), 48'(word_2));
          check_field("word_3", 48'(got_rec.word_3), 48'(word_3));
          check_field("word_4", 48'(got_rec.word_4), 48'(word_4));
          check_field("peer_address", got_rec.peer_address, peer_address);
          check_field("last", 48'(got_rec.last), 48'(last));
        end
        recv_idle = pick_gap(recv_calm);
      end
      if (recv_idle != 0) begin
        recv_idle--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, awaited.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule
